FILE: design/tcc_pkg.sv
package tcc_pkg;

    // Sizing of the counter store
    localparam int TOPIC_COUNT = 17;
    localparam int COUNT_WIDTH = 32;
    localparam int ROW_W       = (TOPIC_COUNT > 1) ? $clog2(TOPIC_COUNT) : 1;
    localparam int TOPIC_W     = 5;
    localparam int OUT_W       = 32;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Topic bound, one bit wider than a topic field
    localparam logic [TOPIC_W:0] TOPIC_LIMIT = (TOPIC_W + 1)'(TOPIC_COUNT);
    localparam logic [ROW_W-1:0] LAST_ROW    = ROW_W'(TOPIC_COUNT - 1);

    // Operation codes on the input channel
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Command kinds passed from front to back
    localparam logic [1:0] CMD_CLOSE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef logic [COUNT_WIDTH-1:0]                  t_count;
    typedef logic [TOPIC_COUNT-1:0]                  t_mask;
    typedef logic [TOPIC_COUNT-1:0][COUNT_WIDTH-1:0] t_row;

    typedef struct packed {
        logic [1:0]         kind;
        t_mask              mask;
        logic [TOPIC_W-1:0] query_first;
        logic [TOPIC_W-1:0] query_second;
    } t_cmd;

    localparam t_count COUNT_MAX = '1;

    // Saturating increment of one counter
    function automatic t_count cnt_inc(input t_count v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

FILE: design/tcc_front.sv
module tcc_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_take,
    input  logic [1:0]             i_operation,
    input  logic [tcc_pkg::TOPIC_W-1:0] i_topic,
    input  logic                   i_last_in_sequence,
    input  logic [tcc_pkg::TOPIC_W-1:0] i_query_first,
    input  logic [tcc_pkg::TOPIC_W-1:0] i_query_second,
    output logic                   o_cmd_push,
    output tcc_pkg::t_cmd          o_cmd
);
    import tcc_pkg::*;

    t_mask r_seen_mask;
    t_mask n_seen_mask;
    t_mask visit_mask;

    // Merge the visit topic into the open sequence
    always_comb begin
        visit_mask = r_seen_mask;
        if ({1'b0, i_topic} < TOPIC_LIMIT) begin
            visit_mask = r_seen_mask | (TOPIC_COUNT'(1) << i_topic);
        end
    end

    // Classify the item into a back-end command
    always_comb begin
        n_seen_mask         = r_seen_mask;
        o_cmd_push          = 1'b0;
        o_cmd.kind          = CMD_CLOSE;
        o_cmd.mask          = visit_mask;
        o_cmd.query_first   = i_query_first;
        o_cmd.query_second  = i_query_second;
        if (i_take) begin
            case (i_operation)
                OP_ADD: begin
                    if (i_last_in_sequence) begin
                        o_cmd_push  = 1'b1;
                        n_seen_mask = '0;
                    end else begin
                        n_seen_mask = visit_mask;
                    end
                end
                OP_READ: begin
                    o_cmd_push = 1'b1;
                    o_cmd.kind = CMD_READ;
                end
                OP_CLEAR: begin
                    o_cmd_push  = 1'b1;
                    o_cmd.kind  = CMD_CLEAR;
                    n_seen_mask = '0;
                end
                default: begin
                    n_seen_mask = r_seen_mask;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_mask <= '0;
        end else begin
            r_seen_mask <= n_seen_mask;
        end
    end

endmodule

FILE: design/tcc_queue.sv
module tcc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcc_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output tcc_pkg::t_cmd o_cmd
);
    import tcc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_cmd             r_slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slots[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store the pushed command
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: design/tcc_back.sv
module tcc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_empty,
    input  tcc_pkg::t_cmd        i_cmd,
    output logic                 o_cmd_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [tcc_pkg::OUT_W-1:0] o_pair_count,
    output logic [tcc_pkg::OUT_W-1:0] o_sequence_total
);
    import tcc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_QWAIT = 2'd3;

    // Counter store: one row per higher topic
    t_row mem [TOPIC_COUNT];

    logic [1:0]             r_state;
    logic [ROW_W-1:0]       r_row;
    t_mask                  r_walk_mask;
    logic [TOPIC_COUNT-1:0] r_row_valid;
    t_count                 r_seq_total;
    t_row                   r_rd_data;
    logic                   r_wr_en;
    logic [ROW_W-1:0]       r_wr_row;
    logic                   r_q_ok;
    logic [ROW_W-1:0]       r_qa_row;
    logic [ROW_W-1:0]       r_qb_row;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_pair;
    logic [OUT_W-1:0]       r_out_total;

    logic                   rd_en;
    logic [ROW_W-1:0]       rd_addr;
    logic                   qa_ok;
    logic                   qb_ok;
    t_row                   base_row;
    t_row                   wr_data;
    t_count                 query_value;

    assign qa_ok = ({1'b0, i_cmd.query_first} < TOPIC_LIMIT);
    assign qb_ok = ({1'b0, i_cmd.query_second} < TOPIC_LIMIT);

    // Pick the next command and the row to read
    always_comb begin
        o_cmd_pop = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = r_row;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    case (i_cmd.kind)
                        CMD_READ: begin
                            if (!r_out_valid) begin
                                o_cmd_pop = 1'b1;
                                rd_en     = qa_ok;
                                rd_addr   = i_cmd.query_first[ROW_W-1:0];
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                rd_en   = r_walk_mask[r_row];
                rd_addr = r_row;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Bump every present pair of the row being written back
    always_comb begin
        base_row = r_row_valid[r_wr_row] ? r_rd_data : '0;
        wr_data  = base_row;
        for (int lo = 0; lo < TOPIC_COUNT; lo++) begin
            if (r_walk_mask[lo] && (ROW_W'(lo) <= r_wr_row)) begin
                wr_data[lo] = cnt_inc(base_row[lo]);
            end
        end
    end

    // Select the queried count
    always_comb begin
        query_value = '0;
        if (r_q_ok && r_row_valid[r_qa_row]) begin
            query_value = r_rd_data[r_qb_row];
        end
    end

    // Read and write the counter store
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
        if (r_wr_en) begin
            mem[r_wr_row] <= wr_data;
        end
    end

    // Sequence the walk, reads and clears
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row       <= '0;
            r_row_valid <= '0;
            r_seq_total <= '0;
            r_wr_en     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_en <= (r_state == ST_WALK) && r_walk_mask[r_row];
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            if (r_wr_en) begin
                r_row_valid[r_wr_row] <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_cmd_pop) begin
                        case (i_cmd.kind)
                            CMD_CLOSE: begin
                                r_walk_mask <= i_cmd.mask;
                                r_row       <= '0;
                                r_seq_total <= cnt_inc(r_seq_total);
                                r_state     <= ST_WALK;
                            end
                            CMD_READ: begin
                                r_q_ok   <= qa_ok && qb_ok &&
                                            (i_cmd.query_first >= i_cmd.query_second);
                                r_qa_row <= i_cmd.query_first[ROW_W-1:0];
                                r_qb_row <= i_cmd.query_second[ROW_W-1:0];
                                r_state  <= ST_QWAIT;
                            end
                            CMD_CLEAR: begin
                                r_row_valid <= '0;
                                r_seq_total <= '0;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_WALK: begin
                    r_wr_row <= r_row;
                    if (r_row == LAST_ROW) begin
                        r_row   <= '0;
                        r_state <= ST_DRAIN;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_IDLE;
                end
                ST_QWAIT: begin
                    r_out_valid <= 1'b1;
                    r_out_pair  <= OUT_W'(query_value);
                    r_out_total <= OUT_W'(r_seq_total);
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_pair_count     = r_out_pair;
    assign o_sequence_total = r_out_total;

endmodule

FILE: design/topic_cooccurrence_counter_core.sv
// Topic co-occurrence counter.
// Input channel: an item is taken at a clock edge with i_push high and o_full
// low. Add-visit items collect topics of the open sequence in a mask; an item
// marked last closes the sequence. Read items return one result; clear items
// zero all counters, the total and the mask.
// Result channel: while o_empty is low the oldest result sits on the result
// ports; it is taken at an edge with i_pop high.
// A front stage classifies items and hands close, read and clear commands
// through a two-entry command queue to the back end, so plain visits are
// taken every cycle while the back end works and the queue is not full.
// A close is popped in the idle state, walks every row of the counter store,
// one row per cycle, and ends in a drain state for the last write-back. With
// the back end idle and the queue empty, a read is popped and its row read,
// then its result is registered from the query wait state.
// Reset clears the mask, the total and per-row valid flags; rows read as zero
// until first written, so no clearing pass is needed.
// When the receiver stalls, one result is held; a further read waits in the
// command queue, and o_full rises once the queue fills.
module topic_cooccurrence_counter_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [1:0]                  i_operation,
    input  logic [tcc_pkg::TOPIC_W-1:0] i_topic,
    input  logic                        i_last_in_sequence,
    input  logic [tcc_pkg::TOPIC_W-1:0] i_query_first,
    input  logic [tcc_pkg::TOPIC_W-1:0] i_query_second,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [tcc_pkg::OUT_W-1:0]   o_pair_count,
    output logic [tcc_pkg::OUT_W-1:0]   o_sequence_total
);
    import tcc_pkg::*;

    logic take;
    logic cmd_push;
    t_cmd cmd_in;
    logic cmd_pop;
    logic cmd_empty;
    t_cmd cmd_out;

    assign take = i_push && !o_full;

    // Classify items and keep the open-sequence mask
    tcc_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_take             (take),
        .i_operation        (i_operation),
        .i_topic            (i_topic),
        .i_last_in_sequence (i_last_in_sequence),
        .i_query_first      (i_query_first),
        .i_query_second     (i_query_second),
        .o_cmd_push         (cmd_push),
        .o_cmd              (cmd_in)
    );

    // Decouple front and back
    tcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_full  (o_full),
        .o_empty (cmd_empty),
        .o_cmd   (cmd_out)
    );

    // Update and read the counter store
    tcc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_empty      (cmd_empty),
        .i_cmd            (cmd_out),
        .o_cmd_pop        (cmd_pop),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_pair_count     (o_pair_count),
        .o_sequence_total (o_sequence_total)
    );

endmodule

FILE: verif/tcc_checker.sv
module tcc_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic                        i_full,
    input  logic [1:0]                  i_operation,
    input  logic [tcc_pkg::TOPIC_W-1:0] i_topic,
    input  logic                        i_last_in_sequence,
    input  logic [tcc_pkg::TOPIC_W-1:0] i_query_first,
    input  logic [tcc_pkg::TOPIC_W-1:0] i_query_second,
    input  logic                        i_pop,
    input  logic                        i_empty,
    input  logic [tcc_pkg::OUT_W-1:0]   i_pair_count,
    input  logic [tcc_pkg::OUT_W-1:0]   i_sequence_total,
    output int                          o_fail_count,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tcc_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] pair_count;
        logic [OUT_W-1:0] sequence_total;
    } t_answer;

    // Shadow state of the counter store
    t_mask   seen_topics;
    t_count  cooccur [TOPIC_COUNT][TOPIC_COUNT];
    t_count  closed_total;
    t_answer answer_q [$];
    int      report_count;

    // Saturating add of one, holding at all ones
    function automatic t_count sat_bump(input t_count v);
        return (&v) ? v : v + t_count'(1);
    endfunction

    // Zero every counter, the total and the open mask
    task automatic clear_store();
        for (int hi = 0; hi < TOPIC_COUNT; hi++)
            for (int lo = 0; lo < TOPIC_COUNT; lo++)
                cooccur[hi][lo] = '0;
        closed_total = '0;
        seen_topics  = '0;
    endtask

    // Close the open sequence: bump diagonal and pair cells, then the total
    task automatic tally_sequence();
        for (int hi = 0; hi < TOPIC_COUNT; hi++) begin
            if (seen_topics[hi]) begin
                for (int lo = 0; lo <= hi; lo++)
                    if (seen_topics[lo])
                        cooccur[hi][lo] = sat_bump(cooccur[hi][lo]);
            end
        end
        closed_total = sat_bump(closed_total);
        seen_topics  = '0;
    endtask

    // Answer of a read: zero when reversed or out of range
    function automatic t_answer lookup_count(input logic [TOPIC_W-1:0] q_hi,
                                             input logic [TOPIC_W-1:0] q_lo);
        t_answer ans;
        ans.pair_count = '0;
        if (int'(q_hi) < TOPIC_COUNT && int'(q_lo) < TOPIC_COUNT && q_hi >= q_lo)
            ans.pair_count = OUT_W'(cooccur[q_hi][q_lo]);
        ans.sequence_total = OUT_W'(closed_total);
        return ans;
    endfunction

    // Watch both channels: check the result first, then apply the new item
    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            clear_store();
            answer_q.delete();
            o_fail_count = 0;
            report_count = 0;
        end else begin
            if (i_pop && !i_empty) begin
                if (answer_q.size() == 0) begin
                    o_fail_count++;
                    if (report_count < 10)
                        $display("%0t ERROR: result with none pending: count=%0d total=%0d",
                                 $time, i_pair_count, i_sequence_total);
                    report_count++;
                end else begin
                    want = answer_q.pop_front();
                    if (i_pair_count !== want.pair_count ||
                        i_sequence_total !== want.sequence_total) begin
                        o_fail_count++;
                        if (report_count < 10)
                            $display("%0t ERROR: pair_count exp %0d got %0d, %s%0d got %0d",
                                     $time, want.pair_count, i_pair_count,
                                     "sequence_total exp ", want.sequence_total,
                                     i_sequence_total);
                        report_count++;
                    end
                end
            end
            if (i_push && !i_full) begin
                case (i_operation)
                    OP_ADD: begin
                        if (int'(i_topic) < TOPIC_COUNT)
                            seen_topics[i_topic] = 1'b1;
                        if (i_last_in_sequence)
                            tally_sequence();
                    end
                    OP_READ:  answer_q = {answer_q,
                                          lookup_count(i_query_first, i_query_second)};
                    OP_CLEAR: clear_store();
                    default: ;
                endcase
            end
        end
        o_pending = answer_q.size();
    end

endmodule

FILE: verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tcc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int ITEM_TARGET  = 1250;
    localparam int QUIET_ITEMS  = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 400;
    localparam int DRAIN_AT     = 800;

    logic               i_clk              = 1'b0;
    logic               i_rst_n            = 1'b0;
    logic               i_push             = 1'b0;
    logic [1:0]         i_operation        = OP_ADD;
    logic [TOPIC_W-1:0] i_topic            = '0;
    logic               i_last_in_sequence = 1'b0;
    logic [TOPIC_W-1:0] i_query_first      = '0;
    logic [TOPIC_W-1:0] i_query_second     = '0;
    logic               i_pop              = 1'b0;
    logic               o_full;
    logic               o_empty;
    logic [OUT_W-1:0]   o_pair_count;
    logic [OUT_W-1:0]   o_sequence_total;

    int fail_count;
    int pending;

    // Run state shared by sender and receiver
    bit quiet_phase = 1'b0;
    bit rx_hold_req = 1'b0;
    int items_sent  = 0;
    int visits_sent = 0;
    int closes_sent = 0;
    int reads_sent  = 0;
    int clears_sent = 0;
    int unused_sent = 0;

    always #5 i_clk = ~i_clk;

    topic_cooccurrence_counter_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (i_push),
        .o_full             (o_full),
        .i_operation        (i_operation),
        .i_topic            (i_topic),
        .i_last_in_sequence (i_last_in_sequence),
        .i_query_first      (i_query_first),
        .i_query_second     (i_query_second),
        .i_pop              (i_pop),
        .o_empty            (o_empty),
        .o_pair_count       (o_pair_count),
        .o_sequence_total   (o_sequence_total)
    );

    tcc_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (i_push),
        .i_full             (o_full),
        .i_operation        (i_operation),
        .i_topic            (i_topic),
        .i_last_in_sequence (i_last_in_sequence),
        .i_query_first      (i_query_first),
        .i_query_second     (i_query_second),
        .i_pop              (i_pop),
        .i_empty            (o_empty),
        .i_pair_count       (o_pair_count),
        .i_sequence_total   (o_sequence_total),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // Offer one item, with an occasional idle burst first; return once taken
    task automatic send_item(input logic [1:0]         op,
                             input logic [TOPIC_W-1:0] topic,
                             input logic               last,
                             input logic [TOPIC_W-1:0] q_hi,
                             input logic [TOPIC_W-1:0] q_lo);
        if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            @(negedge i_clk);
            i_push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        @(negedge i_clk);
        i_push             <= 1'b1;
        i_operation        <= op;
        i_topic            <= topic;
        i_last_in_sequence <= last;
        i_query_first      <= q_hi;
        i_query_second     <= q_lo;
        do @(posedge i_clk); while (o_full);
        items_sent++;
        case (op)
            OP_ADD: begin
                visits_sent++;
                if (last)
                    closes_sent++;
            end
            OP_READ:  reads_sent++;
            OP_CLEAR: clears_sent++;
            default:  unused_sent++;
        endcase
    endtask

    // Mostly in-range topics, some ignored ones at or above the topic count
    function automatic logic [TOPIC_W-1:0] rand_topic();
        if ($urandom_range(0, 6) == 0)
            return TOPIC_W'($urandom_range(TOPIC_COUNT, 31));
        return TOPIC_W'($urandom_range(0, TOPIC_COUNT - 1));
    endfunction

    // Read one cell: mostly valid pairs, some reversed or out of range
    task automatic send_read();
        logic [TOPIC_W-1:0] q_hi;
        logic [TOPIC_W-1:0] q_lo;
        int                 pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            q_hi = TOPIC_W'($urandom_range(0, TOPIC_COUNT - 1));
            q_lo = TOPIC_W'($urandom_range(0, q_hi));
        end else if (pick < 7) begin
            q_hi = TOPIC_W'($urandom_range(0, TOPIC_COUNT - 1));
            q_lo = q_hi;
        end else begin
            q_hi = TOPIC_W'($urandom_range(0, 31));
            q_lo = TOPIC_W'($urandom_range(0, 31));
        end
        send_item(OP_READ, TOPIC_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                  q_hi, q_lo);
    endtask

    // Receiver: random pop gaps, plus one long hold on request
    initial begin
        int pop_gap;
        pop_gap = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                pop_gap     = HOLD_CYCLES;
            end else if (pop_gap == 0 && !quiet_phase && $urandom_range(0, 9) == 0) begin
                pop_gap = $urandom_range(1, 12);
            end
            if (pop_gap > 0) begin
                i_pop <= 1'b0;
                pop_gap--;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int len;
        int pick;
        bit hold_done;
        bit drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: boundaries, reversed and out-of-range reads, empty close, clear
        send_item(OP_READ,  5'd0,  1'b0, 5'd0,  5'd0);
        send_item(OP_ADD,   5'd0,  1'b0, 5'd31, 5'd31);
        send_item(OP_ADD,   5'd16, 1'b1, 5'd0,  5'd0);
        send_item(OP_READ,  5'd0,  1'b0, 5'd16, 5'd0);
        send_item(OP_READ,  5'd31, 1'b1, 5'd16, 5'd16);
        send_item(OP_READ,  5'd0,  1'b0, 5'd0,  5'd0);
        send_item(OP_READ,  5'd0,  1'b0, 5'd0,  5'd16);
        send_item(OP_READ,  5'd0,  1'b0, 5'd31, 5'd0);
        send_item(OP_READ,  5'd0,  1'b0, 5'd17, 5'd17);
        send_item(OP_ADD,   5'd31, 1'b1, 5'd0,  5'd0);
        send_item(OP_ADD,   5'd17, 1'b0, 5'd0,  5'd0);
        send_item(OP_ADD,   5'd5,  1'b0, 5'd0,  5'd0);
        send_item(OP_ADD,   5'd5,  1'b0, 5'd0,  5'd0);
        send_item(OP_ADD,   5'd3,  1'b1, 5'd0,  5'd0);
        send_item(OP_READ,  5'd0,  1'b0, 5'd5,  5'd3);
        send_item(OP_ADD,   5'd7,  1'b0, 5'd0,  5'd0);
        send_item(OP_READ,  5'd0,  1'b0, 5'd7,  5'd7);
        send_item(OP_UNUSED, 5'd9, 1'b1, 5'd31, 5'd31);
        send_item(OP_ADD,   5'd24, 1'b1, 5'd0,  5'd0);
        send_item(OP_READ,  5'd0,  1'b0, 5'd7,  5'd7);
        send_item(OP_READ,  5'd0,  1'b0, 5'd9,  5'd9);
        send_item(OP_CLEAR, 5'd31, 1'b1, 5'd31, 5'd31);
        send_item(OP_READ,  5'd0,  1'b0, 5'd16, 5'd0);
        send_item(OP_ADD,   5'd16, 1'b1, 5'd31, 5'd31);
        send_item(OP_READ,  5'd0,  1'b0, 5'd16, 5'd16);

        // Random: mostly well-formed sequences with reads mixed in
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= ITEM_TARGET - QUIET_ITEMS)
                quiet_phase = 1'b1;
            if (!hold_done && items_sent >= HOLD_AT) begin
                // Stall the receiver and keep offering reads until input backs up
                hold_done   = 1'b1;
                rx_hold_req = 1'b1;
                repeat (8) send_read();
            end
            if (!drain_done && items_sent >= DRAIN_AT) begin
                // Pause until every pending result is out
                drain_done = 1'b1;
                @(negedge i_clk);
                i_push <= 1'b0;
                wait (pending == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                len = $urandom_range(0, 6);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 4) == 0)
                        send_read();
                    send_item(OP_ADD, rand_topic(), 1'b0,
                              TOPIC_W'($urandom_range(0, 31)),
                              TOPIC_W'($urandom_range(0, 31)));
                end
                send_item(OP_ADD, rand_topic(), 1'b1,
                          TOPIC_W'($urandom_range(0, 31)),
                          TOPIC_W'($urandom_range(0, 31)));
            end else if (pick < 90) begin
                send_read();
            end else if (pick < 92) begin
                send_item(OP_CLEAR, TOPIC_W'($urandom_range(0, 31)),
                          1'($urandom_range(0, 1)),
                          TOPIC_W'($urandom_range(0, 31)),
                          TOPIC_W'($urandom_range(0, 31)));
            end else if (pick < 95) begin
                send_item(OP_UNUSED, TOPIC_W'($urandom_range(0, 31)),
                          1'($urandom_range(0, 1)),
                          TOPIC_W'($urandom_range(0, 31)),
                          TOPIC_W'($urandom_range(0, 31)));
            end else begin
                // Noise: stray visits, possibly out of range, randomly closing
                send_item(OP_ADD, TOPIC_W'($urandom_range(0, 31)),
                          1'($urandom_range(0, 1)),
                          TOPIC_W'($urandom_range(0, 31)),
                          TOPIC_W'($urandom_range(0, 31)));
            end
        end

        // Drain, let a last close finish, then report
        @(negedge i_clk);
        i_push <= 1'b0;
        wait (pending == 0);
        repeat (60) @(posedge i_clk);

        $display("Run covered %0d items: %0d visits closing %0d sequences, %0d reads,",
                 items_sent, visits_sent, closes_sent, reads_sent);
        $display("%0d clears, %0d unused ops, one %0d-cycle receiver hold, one full drain",
                 clears_sent, unused_sent, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("topic_cooccurrence_counter_core: match");
        end else begin
            $display("topic_cooccurrence_counter_core: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(5_000_000);
        $display("Timeout with %0d results pending", pending);
        $display("topic_cooccurrence_counter_core: mismatch");
        $finish;
    end

endmodule
